// File: src/fsk_symbol_deframer_crc4_core_macros.svh
// Assertion macros for the checker file of the FSK deframer.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef FSK_SYMBOL_DEFRAMER_CRC4_CORE_MACROS_SVH
`define FSK_SYMBOL_DEFRAMER_CRC4_CORE_MACROS_SVH

// Clocked assertion that an active-low reset disables.
`define FSKDF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("fskdf assertion failed");

// Clocked assertion that is checked during reset as well.
`define FSKDF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("fskdf assertion failed");

`endif

// File: src/fskdf_pkg.sv
// Package of the FSK symbol deframer: symbol codes, register indexes,
// field widths and the result record. Depends on nothing.
`timescale 1ns / 1ps

package fskdf_pkg;

    // Field widths fixed by the stream format.
    localparam int AMP_W     = 16;
    localparam int THR_W     = 16;
    localparam int PAYLOAD_W = 8;
    localparam int CRC_W     = 4;

    // CRC generator x^4 + x^3 + x + 1.
    localparam logic [CRC_W:0] CRC_GENERATOR = 5'h1B;

    // Configuration register indexes.
    localparam logic REG_LOW_THR  = 1'b0;
    localparam logic REG_HIGH_THR = 1'b1;

    // Decision for one symbol slot.
    typedef enum logic [1:0] {
        SYM_ZERO = 2'd0,
        SYM_ONE  = 2'd1,
        SYM_BAD  = 2'd2
    } sym_t;

    // Receiver state, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RECV = 2'b10
    } rx_state_t;

    // One frame report.
    typedef struct packed {
        logic                 bad_symbol;
        logic                 deliver;
        logic                 heartbeat;
        logic                 frame_good;
        logic [CRC_W-1:0]     received_crc;
        logic [PAYLOAD_W-1:0] payload;
    } result_t;

endpackage

// File: src/fsk_symbol_deframer_crc4_core.sv
// Top level of the binary FSK deframer with a 4-bit CRC.
// Depends on fskdf_pkg, fskdf_classify and fskdf_framer.
//
//  Channel | Dir | Contents
//  s_      | in  | tdata[15:0] low_amplitude, tdata[31:16] high_amplitude
//  m_      | out | tdata[7:0] payload, [11:8] received_crc, [12] frame_good,
//          |     | [13] heartbeat, [14] deliver, [15] bad_symbol
//  cfg_    | in  | index 0 low_threshold, index 1 high_threshold
//
// One item is taken every cycle unless a waiting report stalls the input; a
// slot moves from the input register through the classifier and frame logic
// into the result register, which takes the report of a frame when its
// closing symbol leaves the input register and the result register is free.
// Reset clears the frame state and loads both thresholds with 300.
// A waiting report stalls the input register only when it is full.
`timescale 1ns / 1ps

module fsk_symbol_deframer_crc4_core #(
    parameter int DATA_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // low_amplitude, high_amplitude
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // payload, received_crc, frame_good,
                                   // heartbeat, deliver, bad_symbol
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int AW = fskdf_pkg::AMP_W;

    logic [fskdf_pkg::THR_W-1:0] low_thr_reg;
    logic [fskdf_pkg::THR_W-1:0] high_thr_reg;

    logic          in_valid_reg;
    logic [AW-1:0] in_low_reg;
    logic [AW-1:0] in_high_reg;

    logic               out_valid_reg;
    fskdf_pkg::result_t out_data_reg;

    logic               out_free;
    logic               advance;
    logic               s_accept;
    fskdf_pkg::sym_t    sym;
    logic               res_valid;
    fskdf_pkg::result_t res;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thr_reg  <= 16'd300;
            high_thr_reg <= 16'd300;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fskdf_pkg::REG_LOW_THR:  low_thr_reg  <= cfg_wdata;
                fskdf_pkg::REG_HIGH_THR: high_thr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: the result register frees up when empty or taken.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_low_reg  <= s_tdata[AW-1:0];
            in_high_reg <= s_tdata[2*AW-1:AW];
        end
    end

    fskdf_classify u_classify (
        .low_amplitude  (in_low_reg),
        .high_amplitude (in_high_reg),
        .low_threshold  (low_thr_reg),
        .high_threshold (high_thr_reg),
        .sym            (sym)
    );

    fskdf_framer #(
        .DATA_BITS (DATA_BITS)
    ) u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .sym       (sym),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: src/fskdf_classify.sv
// Symbol slot classifier: compares both tone amplitudes to their thresholds.
// Depends on fskdf_pkg.
`timescale 1ns / 1ps

module fskdf_classify (
    input  logic [fskdf_pkg::AMP_W-1:0] low_amplitude,
    input  logic [fskdf_pkg::AMP_W-1:0] high_amplitude,
    input  logic [fskdf_pkg::THR_W-1:0] low_threshold,
    input  logic [fskdf_pkg::THR_W-1:0] high_threshold,
    output fskdf_pkg::sym_t             sym
);

    logic low_above;
    logic low_below;
    logic high_above;
    logic high_below;

    // An amplitude equal to its threshold is neither above nor below.
    assign low_above  = low_amplitude > low_threshold;
    assign low_below  = low_amplitude < low_threshold;
    assign high_above = high_amplitude > high_threshold;
    assign high_below = high_amplitude < high_threshold;

    // Exactly one tone must stand out for a valid symbol.
    always_comb begin
        if (low_above && high_below) begin
            sym = fskdf_pkg::SYM_ZERO;
        end else if (high_above && low_below) begin
            sym = fskdf_pkg::SYM_ONE;
        end else begin
            sym = fskdf_pkg::SYM_BAD;
        end
    end

endmodule

// File: src/fskdf_framer.sv
// Frame assembler: start detection, shift register, running CRC and report.
// Depends on fskdf_pkg.
`timescale 1ns / 1ps

module fskdf_framer #(
    parameter int DATA_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  fskdf_pkg::sym_t    sym,
    output logic               res_valid,
    output fskdf_pkg::result_t res
);

    localparam int FRAME_LEN = DATA_BITS + 5;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);
    localparam int CW        = fskdf_pkg::CRC_W;

    fskdf_pkg::rx_state_t state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [FRAME_LEN-1:0] shift_reg, shift_next;
    logic [CW-1:0]        crc_reg, crc_next;
    logic                 invalid_reg, invalid_next;

    logic                 bit_in;
    logic [CNT_W-1:0]     count_inc;
    logic [FRAME_LEN-1:0] shift_ins;
    logic                 invalid_upd;
    logic [CW:0]          crc_wide;
    logic [CW-1:0]        crc_upd;
    logic                 in_data;
    logic                 last;
    logic [DATA_BITS-1:0] data_bits;
    logic                 good;

    // Per-symbol updates; an invalid slot shifts in a zero.
    assign bit_in      = (sym == fskdf_pkg::SYM_ONE);
    assign count_inc   = count_reg + CNT_W'(1);
    assign shift_ins   = {shift_reg[FRAME_LEN-2:0], bit_in};
    assign invalid_upd = invalid_reg | (sym == fskdf_pkg::SYM_BAD);

    // One step of the non-augmented CRC division, MSB first.
    assign crc_wide = {crc_reg, bit_in};
    assign crc_upd  = crc_wide[CW] ? (crc_wide[CW-1:0] ^ fskdf_pkg::CRC_GENERATOR[CW-1:0])
                                   : crc_wide[CW-1:0];

    // Data symbols follow the heartbeat flag; the CRC bits close the frame.
    assign in_data = (count_inc >= CNT_W'(2)) && (count_inc <= CNT_W'(DATA_BITS + 1));
    assign last    = (count_inc == CNT_W'(FRAME_LEN));

    // Report built from the frame including the current symbol.
    assign data_bits = shift_ins[DATA_BITS+3:4];
    assign good      = (shift_ins[CW-1:0] == crc_reg) && !invalid_upd;

    always_comb begin
        res.payload      = fskdf_pkg::PAYLOAD_W'(data_bits);
        res.received_crc = shift_ins[CW-1:0];
        res.frame_good   = good;
        res.heartbeat    = shift_ins[FRAME_LEN-1];
        res.deliver      = good && !shift_ins[FRAME_LEN-1];
        res.bad_symbol   = invalid_upd;
    end

    assign res_valid = step && (state_reg == fskdf_pkg::ST_RECV) && last;

    // Next state of the receiver.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        crc_next     = crc_reg;
        invalid_next = invalid_reg;
        if (step) begin
            case (state_reg)
                fskdf_pkg::ST_IDLE: begin
                    if (sym == fskdf_pkg::SYM_ONE) begin
                        state_next   = fskdf_pkg::ST_RECV;
                        count_next   = '0;
                        shift_next   = '0;
                        crc_next     = '0;
                        invalid_next = 1'b0;
                    end
                end
                fskdf_pkg::ST_RECV: begin
                    if (last) begin
                        state_next   = fskdf_pkg::ST_IDLE;
                        count_next   = '0;
                        shift_next   = '0;
                        crc_next     = '0;
                        invalid_next = 1'b0;
                    end else begin
                        count_next   = count_inc;
                        shift_next   = shift_ins;
                        invalid_next = invalid_upd;
                        if (in_data) begin
                            crc_next = crc_upd;
                        end
                    end
                end
                default: begin
                    state_next = fskdf_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Receiver state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fskdf_pkg::ST_IDLE;
            count_reg   <= '0;
            shift_reg   <= '0;
            crc_reg     <= '0;
            invalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            crc_reg     <= crc_next;
            invalid_reg <= invalid_next;
        end
    end

endmodule

// File: src/fskdf_checker.sv
// Port-level checker for the FSK deframer, bound to the top level.
// Depends on fsk_symbol_deframer_crc4_core_macros.svh.
`timescale 1ns / 1ps
`include "fsk_symbol_deframer_crc4_core_macros.svh"

module fskdf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A report is never shown right after reset.
    `FSKDF_ASSERT_ALWAYS(a_no_report_after_reset, aclk, !aresetn |=> !m_tvalid)

    // A stalled report stays until taken, unchanged.
    `FSKDF_ASSERT(a_report_held, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `FSKDF_ASSERT(a_report_stable, aclk, aresetn,
        m_tvalid && !m_tready |=> $stable(m_tdata))

    // Delivery needs a good frame that is not a heartbeat.
    `FSKDF_ASSERT(a_deliver_rule, aclk, aresetn,
        m_tvalid |-> (m_tdata[14] == (m_tdata[12] && !m_tdata[13])))

    // A frame with an invalid symbol is never good.
    `FSKDF_ASSERT(a_bad_not_good, aclk, aresetn, m_tvalid && m_tdata[15] |-> !m_tdata[12])

endmodule

bind fsk_symbol_deframer_crc4_core fskdf_checker u_fskdf_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench of fsk_symbol_deframer_crc4_core: it sends symbol slots,
// predicts each frame report and compares it field by field with the output.
// Depends on fskdf_pkg and the RTL of the deframer.
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAME_SYMS    = 13;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // low_amplitude, high_amplitude
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // payload, received_crc, frame_good,
                                   // heartbeat, deliver, bad_symbol
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = fskdf_pkg::REG_LOW_THR;
    logic [15:0] cfg_wdata = '0;

    // Traffic shaping knobs, in percent, and the long receiver hold-off request.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_len       = 0;
    int hold_cnt       = 0;
    int err_count      = 0;
    int cycle_count    = 0;

    // Predicted deframer state and thresholds.
    logic [15:0] low_thr;
    logic [15:0] high_thr;
    logic        rx_active;
    int          rx_count;
    logic [12:0] rx_shift;
    logic        rx_invalid;

    // Frame reports still to come out of the block, oldest first.
    fskdf_pkg::result_t frame_reports[$];

    fsk_symbol_deframer_crc4_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Non-augmented CRC-4 remainder over the payload, MSB first.
    function automatic logic [3:0] crc4_calc(input logic [7:0] data);
        logic [4:0] rem;
        rem = '0;
        for (int i = 7; i >= 0; i--) begin
            rem = {rem[3:0], data[i]};
            if (rem[4])
                rem = rem ^ fskdf_pkg::CRC_GENERATOR;
        end
        return rem[3:0];
    endfunction

    // Decision of one slot against the current thresholds; equality is invalid.
    function automatic fskdf_pkg::sym_t classify_slot(input logic [15:0] lo,
                                                      input logic [15:0] hi);
        if (lo > low_thr && hi < high_thr)
            return fskdf_pkg::SYM_ZERO;
        if (hi > high_thr && lo < low_thr)
            return fskdf_pkg::SYM_ONE;
        return fskdf_pkg::SYM_BAD;
    endfunction

    // Advances the predicted frame state by one slot; returns 1 with a report
    // when the slot closes a frame.
    function automatic bit predict_slot(input logic [15:0] lo, input logic [15:0] hi,
                                        output fskdf_pkg::result_t rep);
        fskdf_pkg::sym_t sym;
        sym = classify_slot(lo, hi);
        rep = '0;
        if (!rx_active) begin
            if (sym == fskdf_pkg::SYM_ONE) begin
                rx_active  = 1'b1;
                rx_count   = 0;
                rx_shift   = '0;
                rx_invalid = 1'b0;
            end
            return 1'b0;
        end
        if (sym == fskdf_pkg::SYM_BAD)
            rx_invalid = 1'b1;
        rx_shift = {rx_shift[11:0], sym == fskdf_pkg::SYM_ONE};
        rx_count++;
        if (rx_count < FRAME_SYMS)
            return 1'b0;
        rep.payload      = rx_shift[11:4];
        rep.received_crc = rx_shift[3:0];
        rep.heartbeat    = rx_shift[12];
        rep.frame_good   = (rx_shift[3:0] == crc4_calc(rx_shift[11:4])) && !rx_invalid;
        rep.deliver      = rep.frame_good && !rep.heartbeat;
        rep.bad_symbol   = rx_invalid;
        rx_active  = 1'b0;
        rx_count   = 0;
        rx_shift   = '0;
        rx_invalid = 1'b0;
        return 1'b1;
    endfunction

    // Picks amplitudes that give the wanted decision; when the thresholds make
    // that decision impossible the slot stays fully random.
    function automatic void make_slot(input fskdf_pkg::sym_t want,
                                      output logic [15:0] lo,
                                      output logic [15:0] hi);
        lo = 16'($urandom);
        hi = 16'($urandom);
        case (want)
            fskdf_pkg::SYM_ZERO: begin
                if (low_thr != 16'hFFFF && high_thr != 16'h0000) begin
                    lo = 16'($urandom_range(65535, int'(low_thr) + 1));
                    hi = 16'($urandom_range(int'(high_thr) - 1, 0));
                end
            end
            fskdf_pkg::SYM_ONE: begin
                if (high_thr != 16'hFFFF && low_thr != 16'h0000) begin
                    hi = 16'($urandom_range(65535, int'(high_thr) + 1));
                    lo = 16'($urandom_range(int'(low_thr) - 1, 0));
                end
            end
            default: begin
                case ($urandom_range(3))
                    0: lo = low_thr;
                    1: hi = high_thr;
                    2: begin
                        lo = 16'($urandom_range(65535, int'(low_thr)));
                        hi = 16'($urandom_range(65535, int'(high_thr)));
                    end
                    default: begin
                        lo = 16'($urandom_range(int'(low_thr), 0));
                        hi = 16'($urandom_range(int'(high_thr), 0));
                    end
                endcase
            end
        endcase
    endfunction

    // Offers one slot, with a random gap first, and predicts it once accepted.
    task automatic send_slot(input logic [15:0] lo, input logic [15:0] hi);
        fskdf_pkg::result_t rep;
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
        if (predict_slot(lo, hi, rep))
            frame_reports.push_back(rep);
    endtask

    // Start symbol followed by heartbeat, payload and CRC; the CRC may be
    // corrupted and one symbol may be replaced by an invalid slot.
    task automatic send_frame(input bit hb, input logic [7:0] data, input bit bad_crc,
                              input int bad_pos);
        logic [12:0] bits;
        logic [15:0] lo;
        logic [15:0] hi;
        bits = {hb, data, crc4_calc(data)};
        if (bad_crc)
            bits[3:0] = bits[3:0] ^ 4'($urandom_range(15, 1));
        make_slot(fskdf_pkg::SYM_ONE, lo, hi);
        send_slot(lo, hi);
        for (int i = FRAME_SYMS - 1; i >= 0; i--) begin
            make_slot(i == bad_pos ? fskdf_pkg::SYM_BAD
                                   : (bits[i] ? fskdf_pkg::SYM_ONE : fskdf_pkg::SYM_ZERO),
                      lo, hi);
            send_slot(lo, hi);
        end
    endtask

    // Stops offering, waits for every report, then lets the pipeline empty.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (frame_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; only called while the block is drained. The write
    // enable is left high for the caller to drop after the last write.
    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == fskdf_pkg::REG_LOW_THR)
            low_thr = val;
        else
            high_thr = val;
    endtask

    task automatic set_thresholds(input logic [15:0] lo_val, input logic [15:0] hi_val);
        write_reg(fskdf_pkg::REG_LOW_THR, lo_val);
        write_reg(fskdf_pkg::REG_HIGH_THR, hi_val);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, plus noise and cut-off frames.
    task automatic run_traffic(input int n_units);
        logic [15:0] lo;
        logic [15:0] hi;
        int          pick;
        for (int n = 0; n < n_units; n++) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                send_frame(1'($urandom_range(1)), 8'($urandom), $urandom_range(99) < 15,
                           $urandom_range(99) < 10 ? int'($urandom_range(12)) : -1);
            end else if (pick < 88) begin
                repeat ($urandom_range(4, 1)) begin
                    case ($urandom_range(2))
                        0: make_slot(fskdf_pkg::SYM_ZERO, lo, hi);
                        1: make_slot(fskdf_pkg::SYM_BAD, lo, hi);
                        default: begin
                            lo = 16'($urandom);
                            hi = 16'($urandom);
                        end
                    endcase
                    send_slot(lo, hi);
                end
            end else begin
                make_slot(fskdf_pkg::SYM_ONE, lo, hi);
                send_slot(lo, hi);
                repeat ($urandom_range(11, 1)) begin
                    make_slot(fskdf_pkg::sym_t'($urandom_range(2)), lo, hi);
                    send_slot(lo, hi);
                end
            end
        end
    endtask

    // Reset thresholds: ignored idle slots, slots equal to a threshold and a
    // frame that carries an invalid symbol.
    task automatic test_directed_slots();
        logic [12:0] bits;
        send_slot(16'hFFFF, 16'h0000);
        send_slot(16'h0000, 16'h0000);
        send_slot(16'd300, 16'hFFFF);
        send_slot(16'd301, 16'd299);
        send_slot(16'h0000, 16'hFFFF);
        bits = {1'b0, 8'hA5, crc4_calc(8'hA5)};
        for (int i = FRAME_SYMS - 1; i >= 0; i--) begin
            if (i == 5)
                send_slot(16'h0000, 16'd300);
            else if (bits[i])
                send_slot(16'h0000, 16'hFFFF);
            else
                send_slot(16'hFFFF, 16'h0000);
        end
        wait_drained();
    endtask

    // Threshold settings including both ends of the register range.
    task automatic test_threshold_sweep();
        logic [15:0] lo_set[6];
        logic [15:0] hi_set[6];
        lo_set = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'd1000};
        hi_set = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFE, 16'd20000};
        for (int i = 0; i < 6; i++) begin
            set_thresholds(lo_set[i], hi_set[i]);
            run_traffic(2);
            wait_drained();
        end
    endtask

    // Random traffic under each idling pattern, with new thresholds per phase.
    task automatic test_idle_phases();
        int src_pct[4];
        int sink_pct[4];
        src_pct  = '{0, 81, 0, 38};
        sink_pct = '{0, 0, 81, 38};
        for (int p = 0; p < 4; p++) begin
            set_thresholds(16'($urandom_range(4000, 1)), 16'($urandom_range(4000, 1)));
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            run_traffic(34);
            wait_drained();
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // Long receiver hold-off while frames keep coming, so the input stalls.
    task automatic test_backpressure();
        set_thresholds(16'd300, 16'd300);
        hold_len = 400;
        for (int n = 0; n < 10; n++)
            send_frame(1'($urandom_range(1)), 8'($urandom), 1'b0, -1);
        wait_drained();
    endtask

    // Receiver ready, with random stalls and the requested hold-off.
    always @(posedge aclk) begin
        if (hold_len > 0) begin
            hold_cnt = hold_len;
            hold_len = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compares each accepted report with the oldest prediction.
    always @(posedge aclk) begin : check_reports
        fskdf_pkg::result_t got;
        fskdf_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (frame_reports.size() == 0) begin
                $error("unexpected frame report %h", got);
                err_count++;
            end else begin
                want = frame_reports.pop_front();
                if (got.payload != want.payload) begin
                    $error("payload: expected %h, got %h", want.payload, got.payload);
                    err_count++;
                end
                if (got.received_crc != want.received_crc) begin
                    $error("received_crc: expected %h, got %h",
                           want.received_crc, got.received_crc);
                    err_count++;
                end
                if (got.frame_good != want.frame_good) begin
                    $error("frame_good: expected %b, got %b",
                           want.frame_good, got.frame_good);
                    err_count++;
                end
                if (got.heartbeat != want.heartbeat) begin
                    $error("heartbeat: expected %b, got %b", want.heartbeat, got.heartbeat);
                    err_count++;
                end
                if (got.deliver != want.deliver) begin
                    $error("deliver: expected %b, got %b", want.deliver, got.deliver);
                    err_count++;
                end
                if (got.bad_symbol != want.bad_symbol) begin
                    $error("bad_symbol: expected %b, got %b",
                           want.bad_symbol, got.bad_symbol);
                    err_count++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        low_thr    = 16'd300;
        high_thr   = 16'd300;
        rx_active  = 1'b0;
        rx_count   = 0;
        rx_shift   = '0;
        rx_invalid = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_slots();
        test_threshold_sweep();
        test_idle_phases();
        test_backpressure();
        wait_drained();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: fsk_symbol_deframer_crc4_core.f
+incdir+src
src/fskdf_pkg.sv
src/fskdf_classify.sv
src/fskdf_framer.sv
src/fsk_symbol_deframer_crc4_core.sv
src/fskdf_checker.sv
dv/tb_top.sv
